// File: hdl/ust_pkg.sv
// Shared types, codes and encode helpers for the UTF stream transcoder.
// No dependencies; used by ust_decode, ust_serializer and the top level.
`default_nettype none

package ust_pkg;

  localparam int unsigned MaxRes = 4;

  // Format register codes; the unused code 3 behaves as UTF-8
  localparam logic [1:0] FMT_UTF8    = 2'd0;
  localparam logic [1:0] FMT_UTF16LE = 2'd1;
  localparam logic [1:0] FMT_UTF16BE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_SURROGATE = 2'd3;

  // Configuration register indexes
  localparam logic REG_IN_FORMAT  = 1'b0;
  localparam logic REG_OUT_FORMAT = 1'b1;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [20:0] code_point;
    logic [1:0]  status;
  } ust_res_t;

  // All results caused by one input item; res[0] goes out first
  typedef struct packed {
    ust_res_t [MaxRes-1:0] res;
    logic [2:0]            count;
  } ust_bundle_t;

  function automatic ust_res_t mk_res(logic [7:0] b, logic [20:0] cp, logic [1:0] st);
    ust_res_t r;
    r.out_byte   = b;
    r.code_point = cp;
    r.status     = st;
    return r;
  endfunction

  function automatic ust_bundle_t single(ust_res_t e);
    ust_bundle_t bd;
    bd        = '0;
    bd.res[0] = e;
    bd.count  = 3'd1;
    return bd;
  endfunction

  function automatic ust_bundle_t prepend(ust_res_t e, ust_bundle_t m);
    ust_bundle_t bd;
    bd          = '0;
    bd.res[0]   = e;
    bd.res[3:1] = m.res[2:0];
    bd.count    = m.count + 3'd1;
    return bd;
  endfunction

  function automatic ust_bundle_t enc_utf8(logic [20:0] cp);
    ust_bundle_t bd;
    bd = '0;
    if (cp <= 21'h7F) begin
      bd.res[0] = mk_res(cp[7:0], cp, ST_OK);
      bd.count  = 3'd1;
    end else if (cp <= 21'h7FF) begin
      bd.res[0] = mk_res({3'b110, cp[10:6]}, cp, ST_OK);
      bd.res[1] = mk_res({2'b10, cp[5:0]}, cp, ST_OK);
      bd.count  = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      bd.res[0] = mk_res({4'b1110, cp[15:12]}, cp, ST_OK);
      bd.res[1] = mk_res({2'b10, cp[11:6]}, cp, ST_OK);
      bd.res[2] = mk_res({2'b10, cp[5:0]}, cp, ST_OK);
      bd.count  = 3'd3;
    end else begin
      bd.res[0] = mk_res({5'b11110, cp[20:18]}, cp, ST_OK);
      bd.res[1] = mk_res({2'b10, cp[17:12]}, cp, ST_OK);
      bd.res[2] = mk_res({2'b10, cp[11:6]}, cp, ST_OK);
      bd.res[3] = mk_res({2'b10, cp[5:0]}, cp, ST_OK);
      bd.count  = 3'd4;
    end
    return bd;
  endfunction

  // One 16-bit unit as two bytes in the output byte order
  function automatic ust_bundle_t enc_unit16(logic [15:0] unit, logic [20:0] cpf, logic le);
    ust_bundle_t bd;
    bd        = '0;
    bd.res[0] = mk_res(le ? unit[7:0] : unit[15:8], cpf, ST_OK);
    bd.res[1] = mk_res(le ? unit[15:8] : unit[7:0], cpf, ST_OK);
    bd.count  = 3'd2;
    return bd;
  endfunction

  function automatic ust_bundle_t enc_utf16(logic [20:0] cp, logic le);
    ust_bundle_t bd;
    ust_bundle_t lo;
    logic [20:0] v;
    v = cp - 21'h10000;
    if (cp >= 21'h10000) begin
      bd          = enc_unit16({6'b110110, v[19:10]}, cp, le);
      lo          = enc_unit16({6'b110111, v[9:0]}, cp, le);
      bd.res[3:2] = lo.res[1:0];
      bd.count    = 3'd4;
    end else begin
      bd = enc_unit16(cp[15:0], cp, le);
    end
    return bd;
  endfunction

  // UTF-8 pass-through of the held bytes, oldest byte first
  function automatic ust_bundle_t pass8(logic [31:0] hb, logic [2:0] hc, logic [20:0] cp);
    ust_bundle_t bd;
    bd = '0;
    case (hc)
      3'd1: begin
        bd.res[0] = mk_res(hb[7:0], cp, ST_OK);
      end
      3'd2: begin
        bd.res[0] = mk_res(hb[15:8], cp, ST_OK);
        bd.res[1] = mk_res(hb[7:0], cp, ST_OK);
      end
      3'd3: begin
        bd.res[0] = mk_res(hb[23:16], cp, ST_OK);
        bd.res[1] = mk_res(hb[15:8], cp, ST_OK);
        bd.res[2] = mk_res(hb[7:0], cp, ST_OK);
      end
      3'd4: begin
        bd.res[0] = mk_res(hb[31:24], cp, ST_OK);
        bd.res[1] = mk_res(hb[23:16], cp, ST_OK);
        bd.res[2] = mk_res(hb[15:8], cp, ST_OK);
        bd.res[3] = mk_res(hb[7:0], cp, ST_OK);
      end
      default: begin
        bd = '0;
      end
    endcase
    bd.count = (hc > 3'd4) ? 3'd4 : hc;
    return bd;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ust_decode.sv
// Format registers, stream state and the single-pass decode of one input byte
// into a bundle of up to four results. Depends on ust_pkg.
`default_nettype none

module ust_decode import ust_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  output ust_bundle_t      bundle_o
);

  logic [1:0]  in_fmt_q, out_fmt_q;
  logic [20:0] pv_q, pv_d;
  logic [1:0]  bl_q, bl_d;
  logic [31:0] hb_q, hb_d;
  logic [2:0]  hc_q, hc_d;
  logic [7:0]  first_q, first_d;
  logic        phase_q, phase_d;
  logic [9:0]  hsb_q, hsb_d;
  logic        hp_q, hp_d;

  logic        in16, out16, le_in, le_out;
  logic [7:0]  b;
  logic        pre_err;
  ust_res_t    pre_e;
  ust_bundle_t main_l;
  logic        fin;
  logic [20:0] fin_cp;
  logic [31:0] fin_hb;
  logic [2:0]  fin_hc;
  logic [15:0] unit;
  logic [20:0] pair_cp;

  assign in16   = (in_fmt_q == FMT_UTF16LE) || (in_fmt_q == FMT_UTF16BE);
  assign out16  = (out_fmt_q == FMT_UTF16LE) || (out_fmt_q == FMT_UTF16BE);
  assign le_in  = (in_fmt_q == FMT_UTF16LE);
  assign le_out = (out_fmt_q == FMT_UTF16LE);
  assign b      = data_byte_i;

  always_comb begin
    pv_d    = pv_q;
    bl_d    = bl_q;
    hb_d    = hb_q;
    hc_d    = hc_q;
    first_d = first_q;
    phase_d = phase_q;
    hsb_d   = hsb_q;
    hp_d    = hp_q;
    pre_err = 1'b0;
    pre_e   = '0;
    main_l  = '0;
    fin     = 1'b0;
    fin_cp  = '0;
    fin_hb  = '0;
    fin_hc  = '0;
    unit    = le_in ? {b, first_q} : {first_q, b};
    pair_cp = 21'h10000 + {1'b0, hsb_q, 10'b0} + {11'b0, unit[9:0]};

    if (in16) begin
      if (!phase_q) begin
        first_d = b;
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (out16) begin
          main_l = enc_unit16(unit, {5'b0, unit}, le_out);
        end else if (hp_q && unit inside {[16'hDC00:16'hDFFF]}) begin
          hp_d   = 1'b0;
          hsb_d  = '0;
          main_l = enc_utf8(pair_cp);
        end else begin
          if (hp_q) begin
            // high surrogate not followed by a low one
            pre_err = 1'b1;
            pre_e   = mk_res(8'h00, {5'b0, 6'b110110, hsb_q}, ST_SURROGATE);
            hp_d    = 1'b0;
            hsb_d   = '0;
          end
          if (unit inside {[16'hD800:16'hDBFF]}) begin
            hsb_d = unit[9:0];
            hp_d  = 1'b1;
          end else if (unit inside {[16'hDC00:16'hDFFF]}) begin
            main_l = single(mk_res(8'h00, {5'b0, unit}, ST_SURROGATE));
          end else begin
            main_l = enc_utf8({5'b0, unit});
          end
        end
      end
    end else begin
      if (bl_q != 2'd0 && b[7:6] == 2'b10) begin
        // continuation byte
        if (bl_q == 2'd1) begin
          fin    = 1'b1;
          fin_cp = {pv_q[14:0], b[5:0]};
          fin_hb = {hb_q[23:0], b};
          fin_hc = hc_q + 3'd1;
        end else begin
          pv_d = {pv_q[14:0], b[5:0]};
          hb_d = {hb_q[23:0], b};
          hc_d = hc_q + 3'd1;
          bl_d = bl_q - 2'd1;
        end
      end else begin
        if (bl_q != 2'd0) begin
          pre_err = 1'b1;
          pre_e   = mk_res(8'h00, 21'd0, ST_TRUNCATED);
        end
        pv_d = '0;
        bl_d = '0;
        hb_d = '0;
        hc_d = '0;
        if (b <= 8'h7F) begin
          fin    = 1'b1;
          fin_cp = {13'b0, b};
          fin_hb = {24'b0, b};
          fin_hc = 3'd1;
        end else if (b inside {[8'hC2:8'hDF]}) begin
          pv_d = {16'b0, b[4:0]};
          bl_d = 2'd1;
          hb_d = {24'b0, b};
          hc_d = 3'd1;
        end else if (b inside {[8'hE0:8'hEF]}) begin
          pv_d = {17'b0, b[3:0]};
          bl_d = 2'd2;
          hb_d = {24'b0, b};
          hc_d = 3'd1;
        end else if (b inside {[8'hF0:8'hF4]}) begin
          pv_d = {18'b0, b[2:0]};
          bl_d = 2'd3;
          hb_d = {24'b0, b};
          hc_d = 3'd1;
        end else begin
          main_l = single(mk_res(8'h00, {13'b0, b}, ST_BAD_LEAD));
        end
      end
      if (fin) begin
        pv_d = '0;
        bl_d = '0;
        hb_d = '0;
        hc_d = '0;
        if (fin_cp > 21'h10FFFF) begin
          main_l = single(mk_res(8'h00, 21'd0, ST_BAD_LEAD));
        end else if (fin_cp inside {[21'hD800:21'hDFFF]}) begin
          main_l = single(mk_res(8'h00, fin_cp, ST_SURROGATE));
        end else if (out16) begin
          main_l = enc_utf16(fin_cp, le_out);
        end else begin
          main_l = pass8(fin_hb, fin_hc, fin_cp);
        end
      end
    end

    bundle_o = pre_err ? prepend(pre_e, main_l) : main_l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fmt_q  <= FMT_UTF8;
      out_fmt_q <= FMT_UTF8;
      pv_q      <= '0;
      bl_q      <= '0;
      hb_q      <= '0;
      hc_q      <= '0;
      first_q   <= '0;
      phase_q   <= 1'b0;
      hsb_q     <= '0;
      hp_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IN_FORMAT:  in_fmt_q  <= cfg_data_i;
        REG_OUT_FORMAT: out_fmt_q <= cfg_data_i;
        default: ;
      endcase
      // any register write restarts the stream
      pv_q    <= '0;
      bl_q    <= '0;
      hb_q    <= '0;
      hc_q    <= '0;
      first_q <= '0;
      phase_q <= 1'b0;
      hsb_q   <= '0;
      hp_q    <= 1'b0;
    end else if (accept_i) begin
      pv_q    <= pv_d;
      bl_q    <= bl_d;
      hb_q    <= hb_d;
      hc_q    <= hc_d;
      first_q <= first_d;
      phase_q <= phase_d;
      hsb_q   <= hsb_d;
      hp_q    <= hp_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ust_serializer.sv
// Result register: holds one bundle and hands its results out one per cycle
// while out_stall_i is low. Depends on ust_pkg.
`default_nettype none

module ust_serializer import ust_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire ust_bundle_t bundle_i,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output ust_res_t         res_o,
  output logic             last_o,
  output logic             hold_o
);

  ust_bundle_t bundle_q;
  logic        valid_q;
  logic [1:0]  idx_q;
  logic [2:0]  last_idx;
  logic        out_acc;

  assign last_idx    = bundle_q.count - 3'd1;
  assign last_o      = (idx_q == last_idx[1:0]);
  assign res_o       = bundle_q.res[idx_q];
  assign out_valid_o = valid_q;
  assign out_acc     = valid_q && !out_stall_i;
  // a new item may enter in the cycle the last result of the current one leaves
  assign hold_o      = valid_q && !(out_acc && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (out_acc && last_o) begin
      valid_q <= 1'b0;
    end else if (out_acc) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/utf_stream_transcoder_top.sv
// Latency: the first result of an item is valid in the cycle after the item is accepted.
// Flow: an item with n results (n = 1..4) holds the result register until the last leaves;
// the next item is taken in the cycle its last result leaves, or every cycle when no results.
// Reset (asynchronous, active low) selects UTF-8 in and out and clears all stream state.
// Top level of the UTF stream transcoder; depends on ust_pkg, ust_decode, ust_serializer.
`default_nettype none

module utf_stream_transcoder_top import ust_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [20:0]      code_point_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  ust_bundle_t bundle;
  ust_res_t    res;
  logic        hold;
  logic        in_acc;
  logic        load;

  assign in_stall_o = hold;
  assign in_acc     = in_valid_i && !hold;
  assign load       = in_acc && (bundle.count != 3'd0);

  ust_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_acc),
    .data_byte_i (data_byte_i),
    .bundle_o    (bundle)
  );

  ust_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .last_o      (last_o),
    .hold_o      (hold)
  );

  assign out_byte_o   = res.out_byte;
  assign code_point_o = res.code_point;
  assign status_o     = res.status;

endmodule

`default_nettype wire

// File: bench/ust_out_checker.sv
// Result checker for the UTF stream transcoder bench: predicts the output bytes of every
// accepted input item and compares them with the block's results in order.
// Depends on ust_pkg for format, status and register codes.
module ust_out_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [1:0]      cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [7:0]      data_byte_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [7:0]      out_byte_i,
  input  logic [20:0]     code_point_i,
  input  logic [1:0]      status_i,
  input  logic            last_i,
  output int unsigned     due_count_o,
  output int unsigned     fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ust_pkg::*;

  typedef struct {
    logic [7:0]  out_byte;
    logic [20:0] code_point;
    logic [1:0]  status;
    logic        last;
  } out_rec_t;

  out_rec_t    bytes_due[$];
  out_rec_t    item_bytes[$];
  out_rec_t    got;
  int unsigned fail_n = 0;

  // Formats and stream state of the predicted transcoder
  logic [1:0]  in_fmt;
  logic [1:0]  out_fmt;
  logic [20:0] part_val;
  logic [1:0]  left_cnt;
  logic [31:0] held;
  logic [2:0]  held_n;
  logic [7:0]  first_byte;
  logic        half_unit;
  logic [9:0]  hi_bits;
  logic        hi_wait;

  function automatic logic out_is16();
    return out_fmt == FMT_UTF16LE || out_fmt == FMT_UTF16BE;
  endfunction

  task automatic push_out(input logic [7:0] b, input logic [20:0] cp, input logic [1:0] st);
    out_rec_t rec;
    rec.out_byte   = b;
    rec.code_point = cp;
    rec.status     = st;
    rec.last       = 1'b0;
    item_bytes.push_back(rec);
  endtask

  task automatic clear_char();
    part_val = '0;
    left_cnt = '0;
    held     = '0;
    held_n   = '0;
  endtask

  task automatic clear_stream();
    clear_char();
    first_byte = '0;
    half_unit  = 1'b0;
    hi_bits    = '0;
    hi_wait    = 1'b0;
  endtask

  task automatic emit_unit16(input logic [15:0] unit, input logic [20:0] cpf);
    if (out_fmt == FMT_UTF16LE) begin
      push_out(unit[7:0], cpf, ST_OK);
      push_out(unit[15:8], cpf, ST_OK);
    end else begin
      push_out(unit[15:8], cpf, ST_OK);
      push_out(unit[7:0], cpf, ST_OK);
    end
  endtask

  task automatic emit_as_utf16(input logic [20:0] cp);
    logic [20:0] v;
    v = cp - 21'h10000;
    if (cp >= 21'h10000) begin
      emit_unit16({6'b110110, v[19:10]}, cp);
      emit_unit16({6'b110111, v[9:0]}, cp);
    end else begin
      emit_unit16(cp[15:0], cp);
    end
  endtask

  task automatic emit_as_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_out(cp[7:0], cp, ST_OK);
    end else if (cp <= 21'h7FF) begin
      push_out({3'b110, cp[10:6]}, cp, ST_OK);
      push_out({2'b10, cp[5:0]}, cp, ST_OK);
    end else if (cp <= 21'hFFFF) begin
      push_out({4'b1110, cp[15:12]}, cp, ST_OK);
      push_out({2'b10, cp[11:6]}, cp, ST_OK);
      push_out({2'b10, cp[5:0]}, cp, ST_OK);
    end else begin
      push_out({5'b11110, cp[20:18]}, cp, ST_OK);
      push_out({2'b10, cp[17:12]}, cp, ST_OK);
      push_out({2'b10, cp[11:6]}, cp, ST_OK);
      push_out({2'b10, cp[5:0]}, cp, ST_OK);
    end
  endtask

  task automatic finish_char();
    logic [20:0] cp;
    logic [31:0] sh;
    int          k;
    cp = part_val;
    if (cp > 21'h10FFFF) begin
      push_out(8'h00, 21'h0, ST_BAD_LEAD);
    end else if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
      push_out(8'h00, cp, ST_SURROGATE);
    end else if (out_is16()) begin
      emit_as_utf16(cp);
    end else begin
      // UTF-8 out: the original bytes, oldest first
      for (k = 0; k < int'(held_n) && k < 4; k++) begin
        sh = held >> (8 * (int'(held_n) - 1 - k));
        push_out(sh[7:0], cp, ST_OK);
      end
    end
    clear_char();
  endtask

  task automatic utf8_lead(input logic [7:0] b);
    held   = {24'd0, b};
    held_n = 3'd1;
    if (b <= 8'h7F) begin
      part_val = {13'd0, b};
      left_cnt = 2'd0;
      finish_char();
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      part_val = {16'd0, b[4:0]};
      left_cnt = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      part_val = {17'd0, b[3:0]};
      left_cnt = 2'd2;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      part_val = {18'd0, b[2:0]};
      left_cnt = 2'd3;
    end else begin
      clear_char();
      push_out(8'h00, {13'd0, b}, ST_BAD_LEAD);
    end
  endtask

  task automatic utf8_take(input logic [7:0] b);
    if (left_cnt == 2'd0) begin
      utf8_lead(b);
    end else if (b[7:6] == 2'b10) begin
      part_val = {part_val[14:0], b[5:0]};
      held     = {held[23:0], b};
      held_n   = held_n + 3'd1;
      left_cnt = left_cnt - 2'd1;
      if (left_cnt == 2'd0) finish_char();
    end else begin
      // sequence cut short: report it, then the byte starts afresh
      push_out(8'h00, 21'h0, ST_TRUNCATED);
      clear_char();
      utf8_lead(b);
    end
  endtask

  task automatic unit_to_utf8(input logic [15:0] unit);
    logic        paired;
    logic [20:0] cp;
    paired = 1'b0;
    if (hi_wait) begin
      hi_wait = 1'b0;
      if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
        cp      = 21'h10000 + {1'b0, hi_bits, unit[9:0]};
        hi_bits = '0;
        paired  = 1'b1;
        emit_as_utf8(cp);
      end else begin
        push_out(8'h00, {5'd0, 6'b110110, hi_bits}, ST_SURROGATE);
        hi_bits = '0;
      end
    end
    if (!paired) begin
      if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
        hi_bits = unit[9:0];
        hi_wait = 1'b1;
      end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
        push_out(8'h00, {5'd0, unit}, ST_SURROGATE);
      end else begin
        emit_as_utf8({5'd0, unit});
      end
    end
  endtask

  task automatic transcode_byte(input logic [7:0] b);
    logic [15:0] unit;
    out_rec_t    tail;
    item_bytes.delete();
    if (in_fmt == FMT_UTF16LE || in_fmt == FMT_UTF16BE) begin
      if (!half_unit) begin
        first_byte = b;
        half_unit  = 1'b1;
      end else begin
        half_unit = 1'b0;
        unit = (in_fmt == FMT_UTF16LE) ? {b, first_byte} : {first_byte, b};
        if (out_is16()) emit_unit16(unit, {5'd0, unit});
        else unit_to_utf8(unit);
      end
    end else begin
      utf8_take(b);
    end
    if (item_bytes.size() > 0) begin
      tail      = item_bytes.pop_back();
      tail.last = 1'b1;
      item_bytes.push_back(tail);
    end
    foreach (item_bytes[i]) bytes_due.push_back(item_bytes[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fmt  = FMT_UTF8;
      out_fmt = FMT_UTF8;
      clear_stream();
      bytes_due.delete();
      due_count_o  <= 0;
      fail_count_o <= fail_n;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected result: out_byte %h code_point %h status %0d",
                 out_byte_i, code_point_i, status_i);
          fail_n++;
        end else begin
          got = bytes_due.pop_front();
          if (out_byte_i !== got.out_byte) begin
            $error("out_byte: expected %h, actual %h", got.out_byte, out_byte_i);
            fail_n++;
          end
          if (code_point_i !== got.code_point) begin
            $error("code_point: expected %h, actual %h", got.code_point, code_point_i);
            fail_n++;
          end
          if (status_i !== got.status) begin
            $error("status: expected %0d, actual %0d", got.status, status_i);
            fail_n++;
          end
          if (last_i !== got.last) begin
            $error("last: expected %b, actual %b", got.last, last_i);
            fail_n++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IN_FORMAT) in_fmt = cfg_data_i;
        else out_fmt = cfg_data_i;
        clear_stream();
      end
      if (in_valid_i && !in_stall_i) transcode_byte(data_byte_i);
      due_count_o  <= bytes_due.size();
      fail_count_o <= fail_n;
    end
  end

endmodule

// File: bench/tb_top.sv
// Bench top for the UTF stream transcoder: clock, reset, format writes, byte stimulus
// with random idling on both channels, and the verdict.
// Depends on ust_pkg, utf_stream_transcoder_top and ust_out_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ust_pkg::*;

  localparam logic [1:0]  FmtSpare   = 2'd3;     // unused code, behaves as UTF-8
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned IdleGap    = 4;
  localparam int unsigned PhaseItems = 24;
  localparam int unsigned NumPhases  = 12;

  localparam logic [1:0] PhaseIn [0:NumPhases-1] = '{
    FMT_UTF8, FMT_UTF8, FMT_UTF8, FMT_UTF16LE, FMT_UTF16BE, FMT_UTF16LE,
    FMT_UTF16LE, FMT_UTF16BE, FMT_UTF16BE, FmtSpare, FmtSpare, FMT_UTF16BE};
  localparam logic [1:0] PhaseOut [0:NumPhases-1] = '{
    FMT_UTF16LE, FMT_UTF8, FMT_UTF16BE, FMT_UTF8, FMT_UTF8, FMT_UTF16LE,
    FMT_UTF16BE, FMT_UTF16LE, FMT_UTF16BE, FmtSpare, FMT_UTF16LE, FmtSpare};

  // extremes, overlong, surrogate, too large, bad lead, cut-short sequence
  localparam logic [7:0] Utf8Dir [0:19] = '{
    8'h00, 8'hC2, 8'h80, 8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4,
    8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF, 8'hC3, 8'h41};
  // UTF-16LE: lone low surrogate, then high surrogate followed by a plain unit
  localparam logic [7:0] Utf16Dir [0:5] = '{8'h00, 8'hDC, 8'h00, 8'hD8, 8'h41, 8'h00};

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = REG_IN_FORMAT;
  logic [1:0]  cfg_data  = FMT_UTF8;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic        last;
  int unsigned due_count;
  int unsigned fail_count;

  logic [1:0]  cur_in     = FMT_UTF8;
  bit          quiet_tx   = 1'b0;
  bit          quiet_rx   = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned phase_sent = 0;
  int unsigned cycle_n    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf_stream_transcoder_top u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .code_point_o (code_point),
    .status_o     (status),
    .last_o       (last)
  );

  ust_out_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .data_byte_i  (data_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .code_point_i (code_point),
    .status_i     (status),
    .last_i       (last),
    .due_count_o  (due_count),
    .fail_count_o (fail_count)
  );

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 50);
  endfunction

  function automatic logic [20:0] rand_scalar();
    int unsigned pick;
    logic [20:0] cp;
    pick = $urandom_range(0, 3);
    if (pick == 0) cp = 21'($urandom_range(0, 'h7F));
    else if (pick == 1) cp = 21'($urandom_range('h80, 'h7FF));
    else if (pick == 2) cp = ($urandom_range(0, 1) == 1) ? 21'($urandom_range('h800, 'hD7FF))
                                                       : 21'($urandom_range('hE000, 'hFFFF));
    else cp = 21'($urandom_range('h10000, 'h10FFFF));
    return cp;
  endfunction

  // receiver stall; a requested long hold is counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LongHold;
      out_stall <= 1'b1;
    end else if (quiet_rx) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    phase_sent++;
    gap = quiet_tx ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      send_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      send_byte({3'b110, cp[10:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      send_byte({4'b1110, cp[15:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else begin
      send_byte({5'b11110, cp[20:18]});
      send_byte({2'b10, cp[17:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic send_unit(input logic [15:0] u);
    if (cur_in == FMT_UTF16LE) begin
      send_byte(u[7:0]);
      send_byte(u[15:8]);
    end else begin
      send_byte(u[15:8]);
      send_byte(u[7:0]);
    end
  endtask

  task automatic utf8_random_step();
    int unsigned r;
    logic [7:0]  lead;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send_utf8(rand_scalar());
    end else if (r < 78) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (r < 86) begin
      // cut short by a non-continuation byte, sometimes after one continuation
      lead = 8'($urandom_range('hC2, 'hF4));
      send_byte(lead);
      if (lead >= 8'hE0 && $urandom_range(0, 1) == 1) send_byte(8'($urandom_range('h80, 'hBF)));
      b = 8'($urandom_range(0, 127));
      if ($urandom_range(0, 1) == 1) b = b | 8'hC0;
      send_byte(b);
    end else if (r < 92) begin
      send_byte(8'hED);
      send_byte(8'($urandom_range('hA0, 'hBF)));
      send_byte(8'($urandom_range('h80, 'hBF)));
    end else begin
      // any lead with random continuations: overlong forms and values past the top
      lead = 8'($urandom_range('hC2, 'hF4));
      send_byte(lead);
      repeat ((lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1)
        send_byte(8'($urandom_range('h80, 'hBF)));
    end
  endtask

  task automatic utf16_random_step();
    int unsigned r;
    logic [15:0] plain;
    r     = $urandom_range(0, 99);
    plain = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 'hD7FF))
                                        : 16'($urandom_range('hE000, 'hFFFF));
    if (r < 55) begin
      send_unit(plain);
    end else if (r < 75) begin
      send_unit(16'hD800 | 16'($urandom_range(0, 'h3FF)));
      send_unit(16'hDC00 | 16'($urandom_range(0, 'h3FF)));
    end else if (r < 83) begin
      send_unit(16'hDC00 | 16'($urandom_range(0, 'h3FF)));
    end else if (r < 91) begin
      send_unit(16'hD800 | 16'($urandom_range(0, 'h3FF)));
      send_unit(plain);
    end else if (r < 98) begin
      send_unit(16'($urandom_range(0, 'hFFFF)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));   // shifts the unit alignment
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
  endtask

  // formats change only while the block is idle
  task automatic set_formats(input logic [1:0] in_f, input logic [1:0] out_f);
    drain();
    repeat (IdleGap) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_IN_FORMAT;
    cfg_data <= in_f;
    @(posedge clk);
    cfg_idx  <= REG_OUT_FORMAT;
    cfg_data <= out_f;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_in = in_f;
  endtask

  initial begin
    while (cycle_n < CycleLimit) begin
      @(posedge clk);
      cycle_n++;
    end
    $error("no completion within %0d cycles", CycleLimit);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(Utf8Dir); i++) send_byte(Utf8Dir[i]);
    send_byte(8'hF0);   // left partial; the format write must drop it
    set_formats(FMT_UTF16LE, FMT_UTF8);
    for (int i = 0; i < $size(Utf16Dir); i++) send_byte(Utf16Dir[i]);

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_formats(PhaseIn[ph], PhaseOut[ph]);
      quiet_tx = (ph % 4 == 3);
      quiet_rx = (ph % 5 == 2);
      if (ph == 1) begin
        // receiver holds off while the sender keeps offering items
        quiet_tx = 1'b1;
        hold_req = 1'b1;
      end
      phase_sent = 0;
      while (phase_sent < PhaseItems) begin
        if (cur_in == FMT_UTF16LE || cur_in == FMT_UTF16BE) utf16_random_step();
        else utf8_random_step();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: utf_stream_transcoder_top.f
hdl/ust_pkg.sv
hdl/ust_decode.sv
hdl/ust_serializer.sv
hdl/utf_stream_transcoder_top.sv
bench/ust_out_checker.sv
bench/tb_top.sv
